[sv/bpc_pkg.sv]
package bpc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TALLY_W = 16;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    localparam logic [CFG_W-1:0] LONG_RESET      = 32'd300;
    localparam logic [CFG_W-1:0] VERY_LONG_RESET = 32'd1000;
    localparam logic [CFG_W-1:0] WINDOW_RESET    = 32'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG      = 2'd0,
        CFG_VERY_LONG = 2'd1,
        CFG_WINDOW    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_SLEEP  = 2'd1,
        KIND_TOGGLE = 2'd2,
        KIND_MULTI  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TALLY_W-1:0] count;
        logic               last;
    } t_event;

    // events produced by one poll, in delivery order
    typedef struct packed {
        t_event     ev0;
        t_event     ev1;
        logic [1:0] num;
    } t_ev_pair;

    typedef struct packed {
        logic [CFG_W-1:0] long_ticks;
        logic [CFG_W-1:0] very_long_ticks;
        logic [CFG_W-1:0] window_ticks;
    } t_cfg;

endpackage

[sv/bpc_in_if.sv]
interface bpc_in_if
    import bpc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              pin_level;
    logic              multi_mode_on;
    logic [TIME_W-1:0] time_now;

    modport source (output valid, output pin_level, output multi_mode_on,
                    output time_now, input ready);
    modport sink   (input valid, input pin_level, input multi_mode_on,
                    input time_now, output ready);
endinterface

[sv/bpc_out_if.sv]
interface bpc_out_if
    import bpc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [TALLY_W-1:0] sequence_count;
    logic               last_event;

    modport source (output valid, output event_kind, output sequence_count,
                    output last_event, input ready);
    modport sink   (input valid, input event_kind, input sequence_count,
                    input last_event, output ready);
endinterface

[sv/bpc_classify.sv]
module bpc_classify
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_level,
    input  logic              i_multi,
    input  logic [TIME_W-1:0] i_now,
    input  t_cfg              i_cfg,
    output t_ev_pair          o_pair
);

    logic               r_held;
    logic [TIME_W-1:0]  r_start;
    logic [TALLY_W-1:0] r_tally;
    logic [TIME_W-1:0]  r_last_short;

    logic               n_held;
    logic [TIME_W-1:0]  n_start;
    logic [TALLY_W-1:0] n_tally;
    logic [TIME_W-1:0]  n_last_short;

    logic [TIME_W-1:0]  dur;
    logic [TIME_W-1:0]  gap;
    logic               rel_ok;
    t_event             rel_ev;
    logic               exp_ok;
    t_event             exp_ev;
    logic               counted;

    function automatic t_event seq_event(input logic [TALLY_W-1:0] cnt);
        t_event e;
        e.last = 1'b0;
        if (cnt == TALLY_W'(1)) begin
            e.kind  = KIND_SHORT;
            e.count = '0;
        end else begin
            e.kind  = KIND_MULTI;
            e.count = cnt;
        end
        return e;
    endfunction

    always_comb begin
        dur          = i_now - r_start;
        gap          = i_now - r_last_short;
        n_held       = !i_level;
        n_start      = (!i_level && !r_held) ? i_now : r_start;
        n_tally      = r_tally;
        n_last_short = r_last_short;
        rel_ok       = 1'b0;
        rel_ev       = '{kind: KIND_SHORT, count: '0, last: 1'b0};
        counted      = 1'b0;

        if (i_level && r_held) begin
            priority if (dur >= i_cfg.very_long_ticks) begin
                rel_ok      = 1'b1;
                rel_ev.kind = KIND_SLEEP;
            end else if (dur >= i_cfg.long_ticks) begin
                rel_ok      = 1'b1;
                rel_ev.kind = KIND_TOGGLE;
            end else if (i_multi) begin
                counted      = 1'b1;
                n_last_short = i_now;
                priority if (r_tally == '0) begin
                    n_tally = TALLY_W'(1);
                end else if (gap <= i_cfg.window_ticks) begin
                    if (r_tally != TALLY_MAX) begin
                        n_tally = r_tally + TALLY_W'(1);
                    end
                end else begin
                    rel_ok  = 1'b1;
                    rel_ev  = seq_event(r_tally);
                    n_tally = TALLY_W'(1);
                end
            end else begin
                rel_ok = 1'b1;
            end
        end

        // a press counted this poll restarts the window, so no expiry is reported this poll
        exp_ok = !counted && (r_tally != '0) && (gap > i_cfg.window_ticks);
        exp_ev = seq_event(r_tally);
        if (exp_ok) begin
            n_tally = '0;
        end

        o_pair = '0;
        if (rel_ok) begin
            o_pair.ev0      = rel_ev;
            o_pair.ev0.last = !exp_ok;
            o_pair.ev1      = exp_ev;
            o_pair.ev1.last = 1'b1;
            o_pair.num      = exp_ok ? 2'd2 : 2'd1;
        end else if (exp_ok) begin
            o_pair.ev0      = exp_ev;
            o_pair.ev0.last = 1'b1;
            o_pair.num      = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 1'b0;
            r_start      <= '0;
            r_tally      <= '0;
            r_last_short <= '0;
        end else if (i_fire) begin
            r_held       <= n_held;
            r_start      <= n_start;
            r_tally      <= n_tally;
            r_last_short <= n_last_short;
        end
    end

endmodule

[sv/bpc_evbuf.sv]
module bpc_evbuf
    import bpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_ev_pair i_pair,
    input  logic     i_ready,
    output logic     o_free,
    output logic     o_valid,
    output t_event   o_ev
);

    logic [1:0] r_num;
    t_event     r_ev0;
    t_event     r_ev1;
    logic       pop;

    assign pop     = (r_num != 2'd0) && i_ready;
    assign o_free  = (r_num == 2'd0) || ((r_num == 2'd1) && i_ready);
    assign o_valid = (r_num != 2'd0);
    assign o_ev    = r_ev0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
        end else if (i_load) begin
            r_num <= i_pair.num;
        end else if (pop) begin
            r_num <= r_num - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev0 <= i_pair.ev0;
            r_ev1 <= i_pair.ev1;
        end else if (pop) begin
            r_ev0 <= r_ev1;
        end
    end

endmodule

[sv/button_press_classifier.sv]
// channel   dir   modport  words per poll   payload
// i_in      in    sink     1                pin_level, multi_mode_on, time_now
// o_out     out   source   0 to 2           event_kind, sequence_count, last_event
// cfg       in    -        -                i_cfg_we, i_cfg_idx, i_cfg_data
//
// a poll word is registered and classified once the buffer is free; its events land in
// a two-entry result buffer; one poll per cycle while o_out is ready and polls yield
// at most one event each; a poll with two events holds the buffer until both are taken
// i_rst_n is synchronous, active low: clears held state, tally and both buffers
// a stall on o_out backs up through the buffer to i_in.ready
module button_press_classifier
    import bpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bpc_in_if.sink               i_in,
    bpc_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    // poll input register
    logic              r_in_valid;
    logic              r_level;
    logic              r_multi;
    logic [TIME_W-1:0] r_now;

    logic     buf_free;
    logic     fire;
    t_ev_pair pair;
    t_event   out_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_ticks      <= LONG_RESET;
            r_cfg.very_long_ticks <= VERY_LONG_RESET;
            r_cfg.window_ticks    <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            // an index past the last register is dropped
            unique case (i_cfg_idx)
                CFG_LONG:      r_cfg.long_ticks      <= i_cfg_data;
                CFG_VERY_LONG: r_cfg.very_long_ticks <= i_cfg_data;
                CFG_WINDOW:    r_cfg.window_ticks    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // the poll in the input register is classified once the buffer can take its events
    assign fire       = r_in_valid && buf_free;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_level <= i_in.pin_level;
            r_multi <= i_in.multi_mode_on;
            r_now   <= i_in.time_now;
        end
    end

    // press timing, short press sequence tracking and event selection
    bpc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_level (r_level),
        .i_multi (r_multi),
        .i_now   (r_now),
        .i_cfg   (r_cfg),
        .o_pair  (pair)
    );

    // result buffer, drained one word per cycle while o_out.ready is high
    bpc_evbuf u_evbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_pair  (pair),
        .i_ready (o_out.ready),
        .o_free  (buf_free),
        .o_valid (o_out.valid),
        .o_ev    (out_ev)
    );

    assign o_out.event_kind     = out_ev.kind;
    assign o_out.sequence_count = out_ev.count;
    assign o_out.last_event     = out_ev.last;

endmodule

[sv/bpc_checker.sv]
module bpc_checker
    import bpc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_kind,
    input logic [TALLY_W-1:0] i_count,
    input logic               i_last
);

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word right after reset");

    // a stalled word holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_kind) && $stable(i_count) && $stable(i_last))
        else $error("stalled output word changed");

    // a word that is not the last of its poll is followed at once by the next one
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> i_out_valid)
        else $error("second event of a poll missing");

    // only a multi press sequence carries a count
    a_count_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_MULTI) || (i_count == '0))
        else $error("count on a non-sequence event");

    // a sequence of one press is reported as a single short
    a_multi_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_MULTI) |-> (i_count != TALLY_W'(1)))
        else $error("sequence of one press reported as multi");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.event_kind),
    .i_count     (o_out.sequence_count),
    .i_last      (o_out.last_event)
);
